// File: sv/rwsub_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rwsub_pkg
// Shared widths, constants and command codes of the rotor wheel substitution
// block.
// -----------------------------------------------------------------------------
package rwsub_pkg;

   // alphabet size default
   localparam int ALPHABET_SIZE = 26;

   // field widths
   localparam int CMD_W    = 3;
   localparam int LETTER_W = 5;
   localparam int NOTCH_W  = 26;

   // csr port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_NOTCH_MASK = 1'b0;

   // rotor commands
   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD     = 3'd0,
      CMD_SET_POS  = 3'd1,
      CMD_STEP     = 3'd2,
      CMD_MAP_FWD  = 3'd3,
      CMD_MAP_BWD  = 3'd4
   } cmd_type;

endpackage

// File: sv/rwsub_if.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rwsub_req_if / rwsub_rsp_if
// Valid/ready channels carrying command items and result items.
// -----------------------------------------------------------------------------
interface rwsub_req_if;
   logic                              valid;
   logic                              ready;
   logic [rwsub_pkg::CMD_W-1:0]       command;
   logic [rwsub_pkg::LETTER_W-1:0]    letter;
   logic [rwsub_pkg::LETTER_W-1:0]    wiring_output;

   modport source (output valid, command, letter, wiring_output, input ready);
   modport sink   (input valid, command, letter, wiring_output, output ready);
endinterface

interface rwsub_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [rwsub_pkg::LETTER_W-1:0]    mapped_letter;
   logic [rwsub_pkg::LETTER_W-1:0]    position;
   logic                              notch_hit;

   modport source (output valid, mapped_letter, position, notch_hit, input ready);
   modport sink   (input valid, mapped_letter, position, notch_hit, output ready);
endinterface

// File: sv/rwsub_ram.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rwsub_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module rwsub_ram #(
   parameter int WIDTH = 5,
   parameter int DEPTH = 26
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/rotor_wheel_substitution_top.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rotor_wheel_substitution_top
// Single cipher rotor: wiring tables in RAM, rotation position, notch mask.
// -----------------------------------------------------------------------------
// The rotor takes one command item per clock cycle while its read stage is not
// stalled by the result side, and returns one result item for each, through the
// stage 1 registers and then the output register. Forward and inverse wiring live
// in two RAMs with registered read data: a map command computes the rotated index
// and issues the read in the accept cycle, and the returned entry is un-rotated in
// stage 1 and captured into the output register. Loads write both RAMs in the
// accept cycle; set and step update the position register at acceptance, so the
// following item sees the new value. Wiring entries that were never loaded read as
// unknown. The notch mask is written through the APB port at byte address 0.
// -----------------------------------------------------------------------------
module rotor_wheel_substitution_top #(
   parameter int ALPHABET_SIZE = rwsub_pkg::ALPHABET_SIZE
) (
   input  logic                              clock,
   input  logic                              reset,
   rwsub_req_if.sink                         req_if,
   rwsub_rsp_if.source                       rsp_if,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [rwsub_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [rwsub_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [rwsub_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                              pready
);

   localparam int POS_W  = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
   localparam int SUM_W  = POS_W + 1;
   localparam int LW     = rwsub_pkg::LETTER_W;

   // csr
   logic [rwsub_pkg::NOTCH_W-1:0] notch_mask_ff;
   logic [rwsub_pkg::NOTCH_W-1:0] notch_mask_in;
   logic                          csr_write;

   // stage 0 (accept)
   logic                accept;
   rwsub_pkg::cmd_type  cmd;
   logic                letter_ok;
   logic                wout_ok;
   logic [POS_W-1:0]    letter_pos;
   logic [SUM_W-1:0]    idx_sum;
   logic [SUM_W-1:0]    idx_mod;
   logic [SUM_W-1:0]    pos_inc;
   logic [POS_W-1:0]    pos_ff;
   logic [POS_W-1:0]    pos_in;
   logic [rwsub_pkg::NOTCH_W-1:0] notch_shift;
   logic                hit;
   logic                fwd_rd;
   logic                bwd_rd;
   logic                load_wr;

   // stage 1 (read in flight)
   logic                s1_valid_ff;
   logic                s1_valid_in;
   logic                s1_map_ff;
   logic                s1_bwd_ff;
   logic [POS_W-1:0]    s1_pos_ff;
   logic                s1_hit_ff;
   logic                s1_advance;
   logic [LW-1:0]       fwd_data;
   logic [LW-1:0]       bwd_data;
   logic [POS_W-1:0]    wire_val;
   logic [SUM_W-1:0]    unrot;
   logic [LW-1:0]       mapped;

   // output register
   logic                out_valid_ff;
   logic                out_valid_in;
   logic [LW-1:0]       out_mapped_ff;
   logic [LW-1:0]       out_pos_ff;
   logic                out_hit_ff;

   // ---------------------------------------------------------------------------
   // configuration port
   // ---------------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      notch_mask_in = notch_mask_ff;
      if (csr_write && (paddr[2] == rwsub_pkg::REG_NOTCH_MASK)) begin
         notch_mask_in = pwdata[rwsub_pkg::NOTCH_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == rwsub_pkg::REG_NOTCH_MASK) begin
         prdata = {{(rwsub_pkg::CSR_DATA_W-rwsub_pkg::NOTCH_W){1'b0}}, notch_mask_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         notch_mask_ff <= '0;
      end else begin
         notch_mask_ff <= notch_mask_in;
      end
   end

   // ---------------------------------------------------------------------------
   // handshake and pipeline flow
   // ---------------------------------------------------------------------------
   assign s1_advance   = s1_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || s1_advance;
   assign accept       = req_if.valid && req_if.ready;

   // ---------------------------------------------------------------------------
   // stage 0: decode, rotate index, position update
   // ---------------------------------------------------------------------------
   assign cmd       = rwsub_pkg::cmd_type'(req_if.command);
   assign letter_ok = 32'(req_if.letter) < ALPHABET_SIZE;
   assign wout_ok   = 32'(req_if.wiring_output) < ALPHABET_SIZE;
   assign letter_pos = POS_W'(req_if.letter);

   // (letter + pos) mod n, both operands below n
   assign idx_sum = {1'b0, letter_pos} + {1'b0, pos_ff};
   assign idx_mod = (idx_sum >= SUM_W'(ALPHABET_SIZE)) ?
                    idx_sum - SUM_W'(ALPHABET_SIZE) : idx_sum;

   assign pos_inc = {1'b0, pos_ff} + SUM_W'(1);

   // next position
   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         unique case (cmd)
            rwsub_pkg::CMD_SET_POS: begin
               if (letter_ok) begin
                  pos_in = letter_pos;
               end
            end
            rwsub_pkg::CMD_STEP: begin
               pos_in = (pos_inc == SUM_W'(ALPHABET_SIZE)) ? '0 : pos_inc[POS_W-1:0];
            end
            default: begin
               pos_in = pos_ff;
            end
         endcase
      end
   end

   // notch lookup on the new position
   assign notch_shift = notch_mask_ff >> pos_in;
   assign hit         = (cmd == rwsub_pkg::CMD_STEP) && notch_shift[0];

   // memory enables
   assign load_wr = accept && (cmd == rwsub_pkg::CMD_LOAD) && letter_ok && wout_ok;
   assign fwd_rd  = accept && (cmd == rwsub_pkg::CMD_MAP_FWD) && letter_ok;
   assign bwd_rd  = accept && (cmd == rwsub_pkg::CMD_MAP_BWD) && letter_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // ---------------------------------------------------------------------------
   // wiring tables
   // ---------------------------------------------------------------------------
   rwsub_ram #(
      .WIDTH (LW),
      .DEPTH (ALPHABET_SIZE)
   ) u_fwd_ram (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr (POS_W'(req_if.letter)),
      .wr_data (req_if.wiring_output),
      .rd_en   (fwd_rd),
      .rd_addr (POS_W'(idx_mod)),
      .rd_data (fwd_data)
   );

   rwsub_ram #(
      .WIDTH (LW),
      .DEPTH (ALPHABET_SIZE)
   ) u_bwd_ram (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr (POS_W'(req_if.wiring_output)),
      .wr_data (req_if.letter),
      .rd_en   (bwd_rd),
      .rd_addr (POS_W'(idx_mod)),
      .rd_data (bwd_data)
   );

   // ---------------------------------------------------------------------------
   // stage 1 registers
   // ---------------------------------------------------------------------------
   assign s1_valid_in = accept || (s1_valid_ff && !s1_advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_map_ff <= fwd_rd || bwd_rd;
         s1_bwd_ff <= bwd_rd;
         s1_pos_ff <= pos_in;
         s1_hit_ff <= hit;
      end
   end

   // (wire - pos) mod n
   assign wire_val = POS_W'(s1_bwd_ff ? bwd_data : fwd_data);
   assign unrot    = (wire_val >= s1_pos_ff) ?
                     {1'b0, wire_val} - {1'b0, s1_pos_ff} :
                     {1'b0, wire_val} + SUM_W'(ALPHABET_SIZE) - {1'b0, s1_pos_ff};
   assign mapped   = s1_map_ff ? LW'(unrot) : '0;

   // ---------------------------------------------------------------------------
   // output register
   // ---------------------------------------------------------------------------
   assign out_valid_in = s1_advance || (out_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         out_mapped_ff <= mapped;
         out_pos_ff    <= LW'(s1_pos_ff);
         out_hit_ff    <= s1_hit_ff;
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.mapped_letter = out_mapped_ff;
   assign rsp_if.position      = out_pos_ff;
   assign rsp_if.notch_hit     = out_hit_ff;

   // ---------------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------------
`ifndef ASSERT_OFF
   // rotor position always stays inside the alphabet
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      32'(pos_ff) < ALPHABET_SIZE)
      else $error("rotor position out of range");

   // a stalled read stage keeps its item
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_advance |=> s1_valid_ff && $stable(s1_pos_ff)
         && $stable(s1_map_ff))
      else $error("stage 1 item lost under stall");

   // no new item enters over a blocked read stage
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_advance |-> !accept)
      else $error("item accepted over a stalled stage");

   // a notch hit only at a position the mask can mark
   a_hit_pos: assert property (@(posedge clock) disable iff (reset)
      s1_advance && s1_hit_ff |-> 32'(s1_pos_ff) < rwsub_pkg::NOTCH_W
         && !s1_map_ff)
      else $error("notch hit outside mask range");
`endif

endmodule

// File: sim/tb_rotor_wheel_substitution_top.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_rotor_wheel_substitution_top
// Self-checking bench for the single cipher rotor. A short table of directed
// commands covers the field extremes, every command and the corner cases.
// Random phases follow, each under its own notch mask, with a full wiring permutation
// loaded at the start of several phases. Every result is checked field by field: for
// typed directed rows against the table's values, otherwise against a shadow model of
// the wiring tables, the position and the notch mask, kept in step with accepted items.
// -----------------------------------------------------------------------------
module tb_rotor_wheel_substitution_top;

   // widths and sizes from the package
   localparam int CMD_W         = rwsub_pkg::CMD_W;
   localparam int LETTER_W      = rwsub_pkg::LETTER_W;
   localparam int NOTCH_W       = rwsub_pkg::NOTCH_W;
   localparam int CSR_ADDR_W    = rwsub_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W    = rwsub_pkg::CSR_DATA_W;
   localparam int ALPHABET_SIZE = rwsub_pkg::ALPHABET_SIZE;

   // bench constants
   localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
   localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;
   localparam int N_PHASES         = 7;
   localparam int ITEMS_PER_PHASE  = 250;
   localparam int HOLD_PHASE       = 2;
   localparam int LONG_HOLD_CYCLES = 80;
   localparam int DRAIN_CYCLES     = 8;
   localparam int WATCHDOG_LIMIT   = 2000;

   typedef struct packed {
      logic [LETTER_W-1:0] mapped;
      logic [LETTER_W-1:0] pos;
      logic                hit;
   } rotor_result_type;

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [LETTER_W-1:0] letter;
      logic [LETTER_W-1:0] wout;
      logic                typed;
      rotor_result_type    want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   // csr port
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   rwsub_req_if req_ch ();
   rwsub_rsp_if rsp_ch ();

   rotor_wheel_substitution_top i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_ch),
      .rsp_if  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #1 clock = ~clock;

   // shadow rotor state
   logic [LETTER_W-1:0] wheel_fwd [ALPHABET_SIZE];
   logic [LETTER_W-1:0] wheel_inv [ALPHABET_SIZE];
   bit                  fwd_loaded [ALPHABET_SIZE];
   bit                  inv_loaded [ALPHABET_SIZE];
   logic [LETTER_W-1:0] wheel_pos;
   logic [NOTCH_W-1:0]  notch_bits;

   rotor_result_type pending_results[$];
   stim_row_type     stim_rows[$];

   int  mismatch_count;
   int  results_seen;
   int  idle_cycles;
   int  phase_num;
   int  burst_left;
   bit  sender_bursty;
   bit  rsp_steady;
   bit  hold_done;

   // letter through the wheel, rotated in and rotated back out
   function automatic logic [LETTER_W-1:0] through_wheel(bit backward,
                                                         logic [LETTER_W-1:0] x);
      int idx;
      int w;
      idx = (int'(x) + int'(wheel_pos)) % ALPHABET_SIZE;
      w   = backward ? int'(wheel_inv[idx]) : int'(wheel_fwd[idx]);
      w   = w % ALPHABET_SIZE;
      return LETTER_W'((w + ALPHABET_SIZE - int'(wheel_pos)) % ALPHABET_SIZE);
   endfunction

   // apply one command to the shadow rotor and return its result
   function automatic rotor_result_type rotor_apply(logic [CMD_W-1:0] cmd,
                                                    logic [LETTER_W-1:0] letter,
                                                    logic [LETTER_W-1:0] wout);
      rotor_result_type res;
      res = '0;
      unique case (cmd)
         rwsub_pkg::CMD_LOAD: begin
            if (letter < ALPHABET_SIZE && wout < ALPHABET_SIZE) begin
               wheel_fwd[letter] = wout;
               wheel_inv[wout]   = letter;
               fwd_loaded[letter] = 1'b1;
               inv_loaded[wout]   = 1'b1;
            end
         end
         rwsub_pkg::CMD_SET_POS: begin
            if (letter < ALPHABET_SIZE)
               wheel_pos = letter;
         end
         rwsub_pkg::CMD_STEP: begin
            wheel_pos = LETTER_W'((int'(wheel_pos) + 1) % ALPHABET_SIZE);
            res.hit   = notch_bits[wheel_pos];
         end
         rwsub_pkg::CMD_MAP_FWD: begin
            if (letter < ALPHABET_SIZE)
               res.mapped = through_wheel(1'b0, letter);
         end
         rwsub_pkg::CMD_MAP_BWD: begin
            if (letter < ALPHABET_SIZE)
               res.mapped = through_wheel(1'b1, letter);
         end
         default: ;
      endcase
      res.pos = wheel_pos;
      return res;
   endfunction

   task automatic log_mismatch(string what, int got, int want);
      $display("%0t mismatch %s on result %0d: got %0d expected %0d",
               $time, what, results_seen, got, want);
      mismatch_count++;
   endtask

   task automatic add_row(logic [CMD_W-1:0] cmd, int letter, int wout, bit typed,
                          int mapped, int pos, bit hit);
      stim_row_type row;
      row.cmd         = cmd;
      row.letter      = LETTER_W'(letter);
      row.wout        = LETTER_W'(wout);
      row.typed       = typed;
      row.want.mapped = LETTER_W'(mapped);
      row.want.pos    = LETTER_W'(pos);
      row.want.hit    = hit;
      stim_rows.push_back(row);
   endtask

   // offer one item, in bursts when asked, and record its expected result
   task automatic send_item(logic [CMD_W-1:0] cmd, logic [LETTER_W-1:0] letter,
                            logic [LETTER_W-1:0] wout, bit typed,
                            rotor_result_type typed_res);
      rotor_result_type res;
      if (sender_bursty) begin
         if (burst_left == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = $urandom_range(1, 12);
         end
         burst_left--;
      end
      req_ch.valid         <= 1'b1;
      req_ch.command       <= cmd;
      req_ch.letter        <= letter;
      req_ch.wiring_output <= wout;
      do @(posedge clock); while (!req_ch.ready);
      res = rotor_apply(cmd, letter, wout);
      pending_results.push_back(typed ? typed_res : res);
   endtask

   task automatic write_notch_mask(logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(4 * int'(rwsub_pkg::REG_NOTCH_MASK));
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      notch_bits = value[NOTCH_W-1:0];
   endtask

   // stop offering items and let every pending result drain
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // well-formed sequence: a full random permutation, loaded in random order
   task automatic load_permutation();
      int perm [ALPHABET_SIZE];
      int order [ALPHABET_SIZE];
      int j;
      int t;
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
         perm[i]  = i;
         order[i] = i;
      end
      for (int i = ALPHABET_SIZE - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = perm[i]; perm[i] = perm[j]; perm[j] = t;
         j = $urandom_range(0, i);
         t = order[i]; order[i] = order[j]; order[j] = t;
      end
      for (int i = 0; i < ALPHABET_SIZE; i++)
         send_item(rwsub_pkg::CMD_LOAD, LETTER_W'(order[i]), LETTER_W'(perm[order[i]]),
                   1'b0, '0);
   endtask

   // one random command, never reading a wiring entry that was never loaded
   task automatic send_random_item();
      logic [CMD_W-1:0]    cmd;
      logic [LETTER_W-1:0] letter;
      logic [LETTER_W-1:0] wout;
      int                  r;
      int                  idx;
      r      = $urandom_range(0, 99);
      letter = LETTER_W'($urandom_range(0, 31));
      wout   = LETTER_W'($urandom_range(0, 31));
      if (r < 8) begin
         cmd = rwsub_pkg::CMD_LOAD;
         if ($urandom_range(0, 7) != 0) letter = LETTER_W'($urandom_range(0, 25));
         if ($urandom_range(0, 7) != 0) wout   = LETTER_W'($urandom_range(0, 25));
      end
      else if (r < 16)
         cmd = rwsub_pkg::CMD_SET_POS;
      else if (r < 45)
         cmd = rwsub_pkg::CMD_STEP;
      else if (r < 93) begin
         cmd = (r < 70) ? rwsub_pkg::CMD_MAP_FWD : rwsub_pkg::CMD_MAP_BWD;
         if ($urandom_range(0, 9) != 0) letter = LETTER_W'($urandom_range(0, 25));
         if (letter < ALPHABET_SIZE) begin
            idx = (int'(letter) + int'(wheel_pos)) % ALPHABET_SIZE;
            if ((cmd == rwsub_pkg::CMD_MAP_FWD) ? !fwd_loaded[idx] : !inv_loaded[idx])
               letter = LETTER_W'(ALPHABET_SIZE);
         end
      end
      else
         cmd = CMD_W'($urandom_range(int'(CMD_UNUSED_LO), int'(CMD_UNUSED_HI)));
      send_item(cmd, letter, wout, 1'b0, '0);
   endtask

   // result checker
   always @(posedge clock) begin : check_results
      rotor_result_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
         if (pending_results.size() == 0)
            log_mismatch("unexpected result, position", int'(rsp_ch.position), -1);
         else begin
            want = pending_results.pop_front();
            if (rsp_ch.mapped_letter !== want.mapped)
               log_mismatch("mapped_letter", int'(rsp_ch.mapped_letter), int'(want.mapped));
            if (rsp_ch.position !== want.pos)
               log_mismatch("position", int'(rsp_ch.position), int'(want.pos));
            if (rsp_ch.notch_hit !== want.hit)
               log_mismatch("notch_hit", int'(rsp_ch.notch_hit), int'(want.hit));
         end
         results_seen++;
      end
   end

   // watchdog on cycles with no item moving
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("RESULT: ERROR");
         $finish;
      end
      else
         idle_cycles <= idle_cycles + 1;
   end

   // result side pacing, with one long hold-off
   initial begin : rsp_pacer
      int run_len;
      int stall_len;
      int hold_count;
      rsp_ch.ready = 1'b0;
      hold_done    = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (phase_num == HOLD_PHASE && !hold_done) begin
            hold_done = 1'b1;
            rsp_ch.ready <= 1'b0;
            for (hold_count = 0; hold_count < LONG_HOLD_CYCLES; hold_count++)
               @(posedge clock);
         end
         else if (rsp_steady) begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end
         else begin
            run_len   = $urandom_range(1, 8);
            stall_len = $urandom_range(1, 5);
            rsp_ch.ready <= 1'b1;
            repeat (run_len) @(posedge clock);
            rsp_ch.ready <= 1'b0;
            repeat (stall_len) @(posedge clock);
         end
      end
   end

   // main sequence
   initial begin : stimulus
      logic [CSR_DATA_W-1:0] mask;
      reset                = 1'b1;
      psel                 = 1'b0;
      penable              = 1'b0;
      pwrite               = 1'b0;
      paddr                = '0;
      pwdata               = '0;
      req_ch.valid         = 1'b0;
      req_ch.command       = rwsub_pkg::CMD_LOAD;
      req_ch.letter        = '0;
      req_ch.wiring_output = '0;
      mismatch_count       = 0;
      results_seen         = 0;
      idle_cycles          = 0;
      phase_num            = -1;
      burst_left           = 0;
      sender_bursty        = 1'b1;
      rsp_steady           = 1'b0;
      wheel_pos            = '0;
      notch_bits           = '0;
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
         wheel_fwd[i]  = '0;
         wheel_inv[i]  = '0;
         fwd_loaded[i] = 1'b0;
         inv_loaded[i] = 1'b0;
      end

      // directed rows: position wrap, out of range letters, unused commands,
      // ignored loads, a load that breaks the permutation, stale inverse entry
      add_row(rwsub_pkg::CMD_STEP,       0,  0, 1, 0,  1, 0);
      add_row(rwsub_pkg::CMD_SET_POS,   25,  0, 1, 0, 25, 0);
      add_row(rwsub_pkg::CMD_STEP,       0,  0, 1, 0,  0, 0);
      add_row(rwsub_pkg::CMD_SET_POS,   26,  0, 1, 0,  0, 0);
      add_row(rwsub_pkg::CMD_SET_POS,   31,  0, 1, 0,  0, 0);
      add_row(rwsub_pkg::CMD_SET_POS,   13,  0, 1, 0, 13, 0);
      add_row(CMD_UNUSED_LO,             7,  9, 1, 0, 13, 0);
      add_row(CMD_UNUSED_HI,            31, 31, 1, 0, 13, 0);
      add_row(rwsub_pkg::CMD_MAP_FWD,   26,  0, 1, 0, 13, 0);
      add_row(rwsub_pkg::CMD_MAP_BWD,   31,  0, 1, 0, 13, 0);
      add_row(rwsub_pkg::CMD_LOAD,      26,  3, 1, 0, 13, 0);
      add_row(rwsub_pkg::CMD_LOAD,       3, 31, 1, 0, 13, 0);
      add_row(rwsub_pkg::CMD_LOAD,       0, 25, 1, 0, 13, 0);
      add_row(rwsub_pkg::CMD_LOAD,      25,  0, 1, 0, 13, 0);
      add_row(rwsub_pkg::CMD_MAP_FWD,   13,  0, 0, 0,  0, 0);
      add_row(rwsub_pkg::CMD_MAP_BWD,   12,  0, 0, 0,  0, 0);
      add_row(rwsub_pkg::CMD_LOAD,       0,  0, 0, 0,  0, 0);
      add_row(rwsub_pkg::CMD_MAP_FWD,   13,  0, 0, 0,  0, 0);
      add_row(rwsub_pkg::CMD_MAP_BWD,   13,  0, 0, 0,  0, 0);
      add_row(rwsub_pkg::CMD_MAP_BWD,   12,  0, 0, 0,  0, 0);
      add_row(rwsub_pkg::CMD_SET_POS,    0,  0, 1, 0,  0, 0);
      add_row(rwsub_pkg::CMD_MAP_FWD,   25,  0, 0, 0,  0, 0);
      add_row(rwsub_pkg::CMD_MAP_BWD,    0,  0, 0, 0,  0, 0);
      add_row(rwsub_pkg::CMD_LOAD,      25, 25, 0, 0,  0, 0);
      add_row(rwsub_pkg::CMD_MAP_FWD,   25,  0, 0, 0,  0, 0);

      // synchronous reset, then release
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_rows[i])
         send_item(stim_rows[i].cmd, stim_rows[i].letter, stim_rows[i].wout,
                   stim_rows[i].typed, stim_rows[i].want);

      // random phases, one notch mask each
      for (int ph = 0; ph < N_PHASES; ph++) begin
         wait_drained();
         case (ph)
            0:       mask = 32'h03FF_FFFF;
            1:       mask = 32'h0000_0000;
            2:       mask = 32'hFFFF_FFFF;
            3:       mask = 32'h0000_0001;
            4:       mask = 32'h0200_0000;
            default: mask = $urandom;
         endcase
         write_notch_mask(mask);
         phase_num     = ph;
         sender_bursty = (ph != 0 && ph != HOLD_PHASE);
         rsp_steady    = (ph == 0 || ph == 4);
         burst_left    = 0;
         if (ph == 0 || ph == 3 || ph == 5)
            load_permutation();
         repeat (ITEMS_PER_PHASE) send_random_item();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
